FILE: sv/bcq_pkg.sv
`default_nettype none

package bcq_pkg;

	// Sample format and channel limits
	localparam int SAMPLE_BITS  = 24;
	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_W       = 3;

	// Configuration register widths
	localparam int STEP_W    = 17;
	localparam int COUNT_W   = 4;
	localparam int MULT_W    = 44;
	localparam int RECIP_W   = 40;
	localparam int CFG_W     = 44;
	localparam int CFG_IDX_W = 2;

	// Phase accumulator, unsigned Q1.16
	localparam int PHASE_W = 17;
	localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
	localparam logic [PHASE_W-1:0] PHASE_MAX = 17'h1FFFF;

	// Quantizer arithmetic
	localparam int K1          = SAMPLE_BITS + 15;  // shift after level_mult
	localparam int K2          = 41 - SAMPLE_BITS;  // shift after level_recip
	localparam int MAG_W       = SAMPLE_BITS;       // |x| up to 2^(SAMPLE_BITS-1)
	localparam int Q_W         = 29;                // integer level magnitude
	localparam int MUL_A_W     = (MAG_W > Q_W) ? MAG_W : Q_W;
	localparam int MUL_B_W     = 22;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int ACC_W       = (SAMPLE_BITS + 45 > 70) ? SAMPLE_BITS + 45 : 70;
	localparam int MULT_SPLIT  = 22;
	localparam int RECIP_SPLIT = 20;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOWNSAMPLE_STEP = 2'd0,
		REG_CHANNEL_COUNT   = 2'd1,
		REG_LEVEL_MULT      = 2'd2,
		REG_LEVEL_RECIP     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_FLUSH   = 2'd0,
		OP_HOLD    = 2'd1,
		OP_CAPTURE = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t                      kind;
		logic [CHAN_W-1:0]             chan;
		logic signed [SAMPLE_BITS-1:0] sample;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

FILE: sv/bcq_queue.sv
`default_nettype none

module bcq_queue import bcq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire op_t       push_op,
	input  wire logic      pop,
	output op_t            head_op,
	output q_status_t      status
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_op      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: sv/bcq_front.sv
`default_nettype none

module bcq_front import bcq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic [STEP_W-1:0]             downsample_step,
	input  wire logic [COUNT_W-1:0]            channel_count,
	input  wire q_status_t                     q_status,
	output logic                               push,
	output op_t                                push_op
);

	logic [PHASE_W-1:0] phase_q;
	logic [CHAN_W-1:0]  pos_q;
	logic               capture_q;

	logic [COUNT_W-1:0] n_eff;
	logic [CHAN_W-1:0]  pos_eff;
	logic               frame_start;
	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W-1:0] phase_mid;
	logic               capture;
	logic               last_chan;
	logic [PHASE_W-1:0] phase_next;
	logic [CHAN_W-1:0]  pos_next;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// channel count clamp and frame position
	always_comb begin
		if (channel_count == '0) begin
			n_eff = COUNT_W'(1);
		end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
			n_eff = COUNT_W'(MAX_CHANNELS);
		end else begin
			n_eff = channel_count;
		end
		pos_eff     = ({1'b0, pos_q} >= n_eff) ? '0 : pos_q;
		frame_start = (pos_eff == '0);
		last_chan   = (({1'b0, pos_eff} + 1'b1) >= n_eff);
	end

	// phase step at frame start, saturating
	always_comb begin
		phase_sum = {1'b0, phase_q} + {1'b0, downsample_step};
		if (frame_start) begin
			phase_mid = (phase_sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : phase_sum[PHASE_W-1:0];
			capture   = (phase_mid >= PHASE_ONE);
		end else begin
			phase_mid = phase_q;
			capture   = capture_q;
		end
		phase_next = (last_chan && capture) ? phase_mid - PHASE_ONE : phase_mid;
		pos_next   = last_chan ? '0 : pos_eff + 1'b1;
	end

	// classify the item for the back end
	always_comb begin
		push_op.chan   = pos_eff;
		push_op.sample = sample_in;
		if (cmd) begin
			push_op.kind = OP_FLUSH;
		end else if (capture) begin
			push_op.kind = OP_CAPTURE;
		end else begin
			push_op.kind = OP_HOLD;
		end
	end

	// frame state, kept across flushes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			pos_q     <= '0;
			capture_q <= 1'b0;
		end else if (push && !cmd) begin
			phase_q   <= phase_next;
			pos_q     <= pos_next;
			capture_q <= capture;
		end
	end

	a_capture_at_full_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd && frame_start && capture) |=> capture_q)
		else $error("capture flag lost at frame start");

endmodule

`default_nettype wire

FILE: sv/bcq_back.sv
`default_nettype none

module bcq_back import bcq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [MULT_W-1:0]       level_mult,
	input  wire logic [RECIP_W-1:0]      level_recip,
	input  wire q_status_t               q_status,
	input  wire op_t                     head_op,
	output logic                         pop,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [CHAN_W-1:0]            channel_index
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_M0   = 7'b0000010,
		ST_M1   = 7'b0000100,
		ST_M2   = 7'b0001000,
		ST_R0   = 7'b0010000,
		ST_R1   = 7'b0100000,
		ST_R2   = 7'b1000000
	} state_t;

	localparam logic [ACC_W-1:0] HALF1 = ACC_W'(1) << (K1 - 1);
	localparam logic [ACC_W-1:0] HALF2 = ACC_W'(1) << (K2 - 1);
	localparam logic [ACC_W-1:0] SMAX  = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [ACC_W-1:0] SMIN_MAG = ACC_W'(64'd1 << (SAMPLE_BITS - 1));

	state_t                        state_q;
	logic [MAG_W-1:0]              mag_q;
	logic                          neg_q;
	logic [CHAN_W-1:0]             chan_q;
	logic [Q_W-1:0]                q_q;
	logic [ACC_W-1:0]              acc_q;
	logic [PROD_W-1:0]             prod_q;
	logic signed [SAMPLE_BITS-1:0] hold_q [MAX_CHANNELS];
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic [CHAN_W-1:0]             chan_out_q;

	logic                          out_free;
	logic                          do_flush;
	logic                          load_hold;
	logic                          start_cap;
	logic                          finish;
	logic                          head_neg;
	logic [MAG_W-1:0]              head_mag;
	logic [MUL_A_W-1:0]            mul_a;
	logic [MUL_B_W-1:0]            mul_b;
	logic [ACC_W-1:0]              sum1;
	logic [ACC_W-1:0]              sum2;
	logic [ACC_W-1:0]              r_mag;
	logic [SAMPLE_BITS-1:0]        r_sat;
	logic signed [SAMPLE_BITS-1:0] y;
	logic [MAX_CHANNELS-1:0]       hold_nz;

	assign out_free      = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign channel_index = chan_out_q;

	// dispatch from the queue head
	always_comb begin
		pop       = 1'b0;
		do_flush  = 1'b0;
		load_hold = 1'b0;
		start_cap = 1'b0;
		if (state_q == ST_IDLE && !q_status.empty) begin
			unique case (head_op.kind)
				OP_FLUSH: begin
					pop      = 1'b1;
					do_flush = 1'b1;
				end
				OP_HOLD: begin
					pop       = out_free;
					load_hold = out_free;
				end
				OP_CAPTURE: begin
					pop       = 1'b1;
					start_cap = 1'b1;
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
		finish = (state_q == ST_R2) && out_free;
	end

	// sign and magnitude of the incoming sample
	assign head_neg = head_op.sample[SAMPLE_BITS-1];
	assign head_mag = head_neg ? MAG_W'(-head_op.sample) : MAG_W'(head_op.sample);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(level_mult[MULT_SPLIT-1:0]);
			end
			ST_M1: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(level_mult[MULT_W-1:MULT_SPLIT]);
			end
			ST_R0: begin
				mul_a = MUL_A_W'(q_q);
				mul_b = MUL_B_W'(level_recip[RECIP_SPLIT-1:0]);
			end
			ST_R1: begin
				mul_a = MUL_A_W'(q_q);
				mul_b = MUL_B_W'(level_recip[RECIP_W-1:RECIP_SPLIT]);
			end
			default: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(level_mult[MULT_SPLIT-1:0]);
			end
		endcase
	end

	// partial product combine, rounding shift and saturation
	always_comb begin
		sum1  = acc_q + (ACC_W'(prod_q) << MULT_SPLIT);
		sum2  = acc_q + (ACC_W'(prod_q) << RECIP_SPLIT);
		r_mag = sum2 >> K2;
		if (neg_q) begin
			r_sat = (r_mag > SMIN_MAG) ? SAMPLE_BITS'(SMIN_MAG) : SAMPLE_BITS'(r_mag);
		end else begin
			r_sat = (r_mag > SMAX) ? SAMPLE_BITS'(SMAX) : SAMPLE_BITS'(r_mag);
		end
		y = neg_q ? -$signed(r_sat) : $signed(r_sat);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= start_cap ? ST_M0 : ST_IDLE;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_R0;
				ST_R0:   state_q <= ST_R1;
				ST_R1:   state_q <= ST_R2;
				ST_R2:   state_q <= out_free ? ST_IDLE : ST_R2;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start_cap) begin
			mag_q  <= head_mag;
			neg_q  <= head_neg;
			chan_q <= head_op.chan;
		end
		if (state_q == ST_M0 || state_q == ST_M1 || state_q == ST_R0 || state_q == ST_R1) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		if (state_q == ST_M1) begin
			acc_q <= ACC_W'(prod_q) + HALF1 - ACC_W'(neg_q);
		end
		if (state_q == ST_R1) begin
			acc_q <= ACC_W'(prod_q) + HALF2 - ACC_W'(neg_q);
		end
		if (state_q == ST_M2) begin
			q_q <= Q_W'(sum1 >> K1);
		end
	end

	// hold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (do_flush) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (finish) begin
			hold_q[chan_q] <= y;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_hold || finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_hold) begin
			sample_out_q <= hold_q[head_op.chan];
			chan_out_q   <= head_op.chan;
		end else if (finish) begin
			sample_out_q <= y;
			chan_out_q   <= chan_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			hold_nz[i] = (hold_q[i] != '0);
		end
	end

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_flush |=> (hold_nz == '0))
		else $error("hold registers not cleared by flush");

	a_wait_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R2 && !out_free) |=> state_q == ST_R2)
		else $error("capture result left while output slot busy");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && state_q == ST_IDLE))
		else $error("capture result not presented");

endmodule

`default_nettype wire

FILE: sv/bitcrusher_sample_hold_quantizer.sv
`default_nettype none
// Bitcrusher: sample-rate reduction by sample-and-hold plus bit-depth quantizer.
// Input channel: in_valid/in_stall with cmd and sample_in (signed Q1.23). cmd 0
// is an interleaved sample, the block tracks the channel position itself; cmd 1
// clears all hold registers and produces no output.
// Output channel: out_valid/out_stall with sample_out and channel_index, one
// result per sample transfer, in input order.
// Config: cfg_we/cfg_index/cfg_data, written only while the block is idle, a
// user's rule the block does not enforce. A held sample goes via the queue to the
// output register; a captured one also runs the six-step sequence through the
// shared 29x22 multiplier (two partial products per multiply). Throughput: one
// flush, or one held sample unless the output stalls, per cycle while the back is
// idle; a capture keeps the back busy until its sequence ends. A two-entry queue
// between the classifying front and the executing back lets input transfers
// continue while the back is busy. Reset clears frame position, phase, holds and
// the output register, and loads register defaults. While out_stall is high the
// result waits in the output register; the queue fills and then in_stall rises.

module bitcrusher_sample_hold_quantizer import bcq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic [CHAN_W-1:0]                  channel_index,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data
);

	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] count_q;
	logic [MULT_W-1:0]  mult_q;
	logic [RECIP_W-1:0] recip_q;

	logic      push;
	op_t       push_op;
	logic      pop;
	op_t       head_op;
	q_status_t q_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_W'(65536);
			count_q <= COUNT_W'(2);
			mult_q  <= '1;
			recip_q <= RECIP_W'(4096);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DOWNSAMPLE_STEP: step_q  <= cfg_data[STEP_W-1:0];
				REG_CHANNEL_COUNT:   count_q <= cfg_data[COUNT_W-1:0];
				REG_LEVEL_MULT:      mult_q  <= cfg_data[MULT_W-1:0];
				REG_LEVEL_RECIP:     recip_q <= cfg_data[RECIP_W-1:0];
			endcase
		end
	end

	bcq_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.sample_in       (sample_in),
		.downsample_step (step_q),
		.channel_count   (count_q),
		.q_status        (q_status),
		.push            (push),
		.push_op         (push_op)
	);

	bcq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.status  (q_status)
	);

	bcq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.level_mult    (mult_q),
		.level_recip   (recip_q),
		.q_status      (q_status),
		.head_op       (head_op),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.channel_index (channel_index)
	);

endmodule

`default_nettype wire

FILE: verif/bitcrusher_sample_hold_quantizer_tb.sv
`default_nettype none

module bitcrusher_sample_hold_quantizer_tb;
	import bcq_pkg::*;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	localparam longint SMAX        = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam int     DRAIN_WAIT  = 16;
	localparam int     PHASE_ITEMS = 650;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_W-1:0]             chan;
	} crushed_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          cmd = CMD_SAMPLE;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [CHAN_W-1:0]             channel_index;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = REG_DOWNSAMPLE_STEP;
	logic [CFG_W-1:0]              cfg_data = '0;

	// Shadow copy of the block's registers and state
	logic [STEP_W-1:0]             step_reg;
	logic [COUNT_W-1:0]            count_reg;
	logic [MULT_W-1:0]             mult_reg;
	logic [RECIP_W-1:0]            recip_reg;
	logic [PHASE_W-1:0]            phase_q;
	int                            frame_pos;
	logic                          capture_on;
	logic signed [SAMPLE_BITS-1:0] hold_val [MAX_CHANNELS];

	crushed_t crushed_q [$];
	int       fail_count = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       holdoff_cycles = 0;

	bitcrusher_sample_hold_quantizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.sample_in     (sample_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.channel_index (channel_index),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// floor((a*b + 2^(k-1)) / 2^k), magnitude capped at 2^40
	function automatic longint round_shift(input longint a, input logic [MULT_W-1:0] b,
			input int k);
		logic [127:0] mag;
		logic [127:0] half;
		logic [127:0] prod;
		logic         neg;
		neg  = a < 0;
		mag  = neg ? {64'd0, -a} : {64'd0, a};
		half = 128'd1 << (k - 1);
		prod = mag * b + (neg ? half - 128'd1 : half);
		prod = prod >> k;
		if (prod > (128'd1 << 40))
			prod = 128'd1 << 40;
		return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
	endfunction

	// Level quantize and scale back to Q1.23, saturated
	function automatic logic signed [SAMPLE_BITS-1:0] quantize_level(
			input logic signed [SAMPLE_BITS-1:0] x);
		longint lvl;
		longint y;
		lvl = round_shift(longint'(x), mult_reg, K1);
		y   = round_shift(lvl, {{(MULT_W-RECIP_W){1'b0}}, recip_reg}, K2);
		if (y > SMAX)
			y = SMAX;
		if (y < -SMAX - 1)
			y = -SMAX - 1;
		return y[SAMPLE_BITS-1:0];
	endfunction

	// Advance the frame tracker by one sample and queue the held value
	task automatic crush_step(input logic signed [SAMPLE_BITS-1:0] x);
		int               n;
		logic [PHASE_W:0] sum;
		crushed_t         e;
		n = count_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_CHANNELS)
			n = MAX_CHANNELS;
		if (frame_pos >= n)
			frame_pos = 0;
		if (frame_pos == 0) begin
			sum = {1'b0, phase_q} + {1'b0, step_reg};
			if (sum > {1'b0, PHASE_MAX})
				sum = {1'b0, PHASE_MAX};
			phase_q    = sum[PHASE_W-1:0];
			capture_on = phase_q >= PHASE_ONE;
		end
		if (capture_on)
			hold_val[frame_pos] = quantize_level(x);
		e.sample = hold_val[frame_pos];
		e.chan   = frame_pos[CHAN_W-1:0];
		crushed_q.push_back(e);
		if (frame_pos + 1 >= n) begin
			if (capture_on)
				phase_q = phase_q - PHASE_ONE;
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
	endtask

	task automatic reset_shadow();
		step_reg   = 17'd65536;
		count_reg  = 4'd2;
		mult_reg   = '1;
		recip_reg  = 40'd4096;
		phase_q    = '0;
		frame_pos  = 0;
		capture_on = 1'b0;
		foreach (hold_val[i])
			hold_val[i] = '0;
	endtask

	// One register write, block idle
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		case (idx)
			REG_DOWNSAMPLE_STEP: step_reg  = val[STEP_W-1:0];
			REG_CHANNEL_COUNT:   count_reg = val[COUNT_W-1:0];
			REG_LEVEL_MULT:      mult_reg  = val[MULT_W-1:0];
			REG_LEVEL_RECIP:     recip_reg = val[RECIP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Matching gain/reciprocal pair for a bit depth of 2..24
	task automatic set_depth(input int bits);
		write_reg(REG_LEVEL_MULT, 44'd1 << (bits - 1 + 16));
		write_reg(REG_LEVEL_RECIP, 44'd1 << (40 - (bits - 1)));
	endtask

	// Offer one item and wait for its transfer
	task automatic send_item(input logic c, input logic signed [SAMPLE_BITS-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		cmd       = c;
		sample_in = s;
		do
			@(posedge clk);
		while (in_stall);
		if (c == CMD_FLUSH) begin
			foreach (hold_val[i])
				hold_val[i] = '0;
		end else begin
			crush_step(s);
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		send_item(CMD_SAMPLE, s);
	endtask

	// Wait for every expected result, then let a flush settle
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (crushed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			2: return SAMPLE_BITS'($signed($urandom_range(15)) - 8);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			out_stall      = 1'b1;
			holdoff_cycles = holdoff_cycles - 1;
		end else begin
			out_stall = $urandom_range(99) < recv_idle_pct;
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		crushed_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (crushed_q.size() == 0) begin
				$error("unexpected result: sample_out %0d channel_index %0d",
					sample_out, channel_index);
				fail_count++;
			end else begin
				e = crushed_q.pop_front();
				if (sample_out !== e.sample) begin
					$error("sample_out: expected %0d, actual %0d", e.sample, sample_out);
					fail_count++;
				end
				if (channel_index !== e.chan) begin
					$error("channel_index: expected %0d, actual %0d", e.chan, channel_index);
					fail_count++;
				end
			end
		end
	end

	// Register defaults after reset: no downsampling, two channels, unity level gain
	task automatic test_reset_defaults();
		send_sample(24'sd1000);
		send_sample(-24'sd1000);
		send_sample(24'sd0);
		drain_results();
	endtask

	// Field extremes through the quantizer, including zero and full-scale gains
	task automatic test_quant_extremes();
		write_reg(REG_DOWNSAMPLE_STEP, 44'd65536);
		write_reg(REG_CHANNEL_COUNT, 44'd1);
		set_depth(8);
		send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
		send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
		send_sample(-24'sd1);
		send_sample(24'sd1);
		drain_results();
		write_reg(REG_LEVEL_MULT, 44'd0);
		send_sample(24'sd12345);
		drain_results();
		write_reg(REG_LEVEL_MULT, '1);
		write_reg(REG_LEVEL_RECIP, {{(CFG_W-RECIP_W){1'b0}}, {RECIP_W{1'b1}}});
		send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
		send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
		drain_results();
	endtask

	// Count of zero acts as one; counts above the maximum clamp
	task automatic test_channel_counts();
		set_depth(12);
		write_reg(REG_CHANNEL_COUNT, 44'd0);
		send_sample(24'sd4096);
		send_sample(-24'sd4096);
		drain_results();
		write_reg(REG_CHANNEL_COUNT, 44'd15);
		for (int i = 0; i < MAX_CHANNELS + 1; i++)
			send_sample(rand_sample());
		drain_results();
	endtask

	// Count lowered while a frame is half done: position wraps to a new frame
	task automatic test_count_drop_midframe();
		write_reg(REG_DOWNSAMPLE_STEP, 44'd32768);
		write_reg(REG_CHANNEL_COUNT, 44'd4);
		send_sample(24'sd100000);
		send_sample(24'sd200000);
		send_sample(24'sd300000);
		drain_results();
		write_reg(REG_CHANNEL_COUNT, 44'd2);
		send_sample(-24'sd100000);
		send_sample(-24'sd200000);
		drain_results();
	endtask

	// Phase saturation with a step above one, then a slow step
	task automatic test_phase_extremes();
		write_reg(REG_CHANNEL_COUNT, 44'd1);
		write_reg(REG_DOWNSAMPLE_STEP, 44'd131071);
		for (int i = 0; i < 3; i++)
			send_sample(rand_sample());
		drain_results();
		write_reg(REG_DOWNSAMPLE_STEP, 44'd1311);
		send_sample(rand_sample());
		send_sample(rand_sample());
		drain_results();
	endtask

	// Flush mid-frame clears the holds and keeps the frame position
	task automatic test_flush();
		write_reg(REG_DOWNSAMPLE_STEP, 44'd65536);
		write_reg(REG_CHANNEL_COUNT, 44'd3);
		send_sample(24'sd500000);
		send_item(CMD_FLUSH, rand_sample());
		drain_results();
		write_reg(REG_DOWNSAMPLE_STEP, 44'd0);
		send_sample(24'sd600000);
		send_sample(24'sd700000);
		drain_results();
	endtask

	// New random register set, block idle
	task automatic randomize_regs();
		logic [63:0] r;
		case ($urandom_range(5))
			0: write_reg(REG_DOWNSAMPLE_STEP, 44'd65536);
			1: write_reg(REG_DOWNSAMPLE_STEP, 44'd1311);
			2: write_reg(REG_DOWNSAMPLE_STEP, 44'($urandom_range(131071, 65537)));
			default: write_reg(REG_DOWNSAMPLE_STEP, 44'($urandom_range(65536, 1311)));
		endcase
		if ($urandom_range(9) == 0)
			write_reg(REG_CHANNEL_COUNT, 44'($urandom_range(15)));
		else
			write_reg(REG_CHANNEL_COUNT, 44'($urandom_range(MAX_CHANNELS, 1)));
		if ($urandom_range(9) < 7) begin
			set_depth($urandom_range(24, 2));
		end else begin
			r = {$urandom, $urandom};
			write_reg(REG_LEVEL_MULT, r[CFG_W-1:0]);
			r = {$urandom, $urandom};
			write_reg(REG_LEVEL_RECIP, {{(CFG_W-RECIP_W){1'b0}}, r[RECIP_W-1:0]});
		end
	endtask

	// Random segments of samples and occasional flushes
	task automatic test_random(input int n_items, input int s_pct, input int r_pct);
		int sent;
		int seg;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < n_items) begin
			randomize_regs();
			seg = $urandom_range(160, 40);
			for (int i = 0; i < seg; i++) begin
				if ($urandom_range(99) < 4)
					send_item(CMD_FLUSH, rand_sample());
				else
					send_sample(rand_sample());
			end
			sent += seg;
			drain_results();
		end
	endtask

	// Long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 10;
		randomize_regs();
		@(posedge clk);
		holdoff_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_sample(rand_sample());
		drain_results();
	endtask

	initial begin
		reset_shadow();
		send_idle_pct = 11;
		recv_idle_pct = 84;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_quant_extremes();
		test_channel_counts();
		test_count_drop_midframe();
		test_phase_extremes();
		test_flush();
		test_random(PHASE_ITEMS, 11, 84);
		test_random(PHASE_ITEMS, 84, 11);
		test_random(PHASE_ITEMS, 0, 0);
		test_backpressure();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
